@@ sv/body_motion_integrator_2d_macros.svh @@
// assertion macros for the body motion integrator
`ifndef BODY_MOTION_INTEGRATOR_2D_MACROS_SVH
`define BODY_MOTION_INTEGRATOR_2D_MACROS_SVH

// same-cycle implication, ignored while in reset
`define BMI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmi check failed");

// next-cycle implication, ignored while in reset
`define BMI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmi check failed");

`endif

@@ sv/bmi_pkg.sv @@
// shared constants and types of the body motion integrator
`default_nettype none
package bmi_pkg;

    localparam int DATA_W  = 32;
    localparam int LIM_W   = 31;
    localparam int FRIC_W  = 16;
    localparam int MS_W    = 10;
    localparam int REST_W  = 16;
    localparam int SCL_W   = 33;
    localparam int FRIC_SH = 8;
    localparam int NUM_W   = LIM_W + FRIC_SH;
    localparam int SC_LAT  = 4;
    localparam int DIV_LAT = NUM_W + 2;
    localparam int TOT_LAT = SC_LAT + 1 + DIV_LAT + SC_LAT + 1;
    localparam int CFG_IDX_W = 3;

    // ceil(2^38 / 125), quotient of (m >> 3) by 125 gives m / 1000
    localparam logic [31:0] RECIP_K = 32'd2199023256;
    localparam int RECIP_SH = 38;

    localparam logic signed [DATA_W-1:0] RST_GRAVITY = 32'sh0000_0000;
    localparam logic signed [DATA_W-1:0] RST_XMIN    = 32'sh0000_0000;
    localparam logic signed [DATA_W-1:0] RST_XMAX    = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] RST_YMIN    = 32'sh0000_0000;
    localparam logic signed [DATA_W-1:0] RST_YMAX    = 32'sh7FFF_FFFF;
    localparam logic [REST_W-1:0]        RST_REST    = 16'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAVITY = 3'd0,
        CFG_XMIN    = 3'd1,
        CFG_XMAX    = 3'd2,
        CFG_YMIN    = 3'd3,
        CFG_YMAX    = 3'd4,
        CFG_REST    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [NUM_W-1:0]  rem_hi;
        logic [FRIC_W-1:0] rem;
        logic [NUM_W-1:0]  num;
        logic [NUM_W-1:0]  quo;
        logic [FRIC_W-1:0] d;
        logic              neg;
        logic              byp;
        logic [DATA_W-1:0] vx;
    } t_div_stage;

    typedef struct packed {
        logic signed [DATA_W-1:0] px;
        logic signed [DATA_W-1:0] py;
        logic signed [DATA_W-1:0] vx;
        logic signed [DATA_W-1:0] vy;
        logic [LIM_W-1:0]         limx;
        logic [LIM_W-1:0]         limy;
        logic [FRIC_W-1:0]        fdiv;
        logic [MS_W-1:0]          ms;
    } t_side_a;

    typedef struct packed {
        logic signed [DATA_W-1:0] px;
        logic signed [DATA_W-1:0] py;
        logic signed [DATA_W-1:0] vy;
        logic [MS_W-1:0]          ms;
    } t_side_c;

    typedef struct packed {
        logic signed [DATA_W-1:0] px;
        logic signed [DATA_W-1:0] py;
        logic signed [DATA_W-1:0] vx;
        logic signed [DATA_W-1:0] vy;
    } t_side_d;

endpackage
`default_nettype wire

@@ sv/bmi_div1k.sv @@
// pipelined signed (value * ms) / 1000, truncating toward zero
`default_nettype none
module bmi_div1k
    import bmi_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic signed [DATA_W-1:0] i_v,
    input  wire logic [MS_W-1:0]          i_ms,
    output logic signed [SCL_W-1:0]       o_q
);

    localparam int P_W = DATA_W + MS_W + 1;
    localparam int M_W = P_W - 2;
    localparam int T_W = M_W - 3;
    localparam int H_W = T_W - 32;
    localparam int PR_W = T_W + 32;

    logic signed [P_W-1:0] w_p;
    logic [P_W-1:0]        w_pa;
    logic [M_W-1:0]        r_m;
    logic                  r_neg0, r_neg1, r_neg2;
    logic [T_W-1:0]        r_t1, r_t2;
    logic [63:0]           r_pl;
    logic [T_W-1:0]        r_ph;
    logic [PR_W-1:0]       w_prod;
    logic [31:0]           r_q0;
    logic [T_W:0]          w_chk;
    logic [31:0]           w_q;
    logic [SCL_W-1:0]      w_qe;
    logic [T_W-1:0]        w_t;

    assign w_p  = $signed(i_v) * $signed({1'b0, i_ms});
    assign w_pa = w_p[P_W-1] ? P_W'(-w_p) : P_W'(w_p);
    assign w_t  = r_m[M_W-1:3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m    <= w_pa[M_W-1:0];
            r_neg0 <= w_p[P_W-1];
            r_t1   <= w_t;
            r_neg1 <= r_neg0;
            r_pl   <= 64'(w_t[31:0]) * 64'(RECIP_K);
            r_ph   <= T_W'(w_t[T_W-1:32]) * T_W'(RECIP_K);
            r_t2   <= r_t1;
            r_neg2 <= r_neg1;
            r_q0   <= w_prod[PR_W-1:RECIP_SH];
            o_q    <= r_neg2 ? $signed(SCL_W'(-w_qe)) : $signed(w_qe);
        end
    end

    assign w_prod = PR_W'(r_pl) + (PR_W'(r_ph) << 32);
    // estimate is exact or one too high
    assign w_chk  = (T_W+1)'(r_q0) * (T_W+1)'(125);
    assign w_q    = (w_chk > {1'b0, r_t2}) ? r_q0 - 32'd1 : r_q0;
    assign w_qe   = {1'b0, w_q};

    logic unused_h;
    assign unused_h = ^H_W;

endmodule
`default_nettype wire

@@ sv/bmi_fric_div.sv @@
// pipelined restoring divider for the friction step on x velocity
`default_nettype none
module bmi_fric_div
    import bmi_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic signed [DATA_W-1:0] i_vx,
    input  wire logic [FRIC_W-1:0]        i_div,
    output logic signed [DATA_W-1:0]      o_vx
);

    localparam logic [NUM_W-1:0] MAX_POS = NUM_W'(64'h7FFF_FFFF);
    localparam logic [NUM_W-1:0] MAX_NEG = NUM_W'(64'h8000_0000);

    t_div_stage        r_st [NUM_W+1];
    logic [DATA_W-1:0] w_abs;
    logic [NUM_W-1:0]  w_q;

    assign w_abs = i_vx[DATA_W-1] ? DATA_W'(-i_vx) : DATA_W'(i_vx);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0].rem_hi <= '0;
            r_st[0].rem    <= '0;
            r_st[0].num    <= {w_abs[LIM_W-1:0], FRIC_SH'(0)};
            r_st[0].quo    <= '0;
            r_st[0].d      <= i_div;
            r_st[0].neg    <= i_vx[DATA_W-1];
            r_st[0].byp    <= (i_vx == '0) || (i_div == '0);
            r_st[0].vx     <= i_vx;
        end
    end

    for (genvar k = 0; k < NUM_W; k++) begin : g_iter
        logic [FRIC_W:0] w_trial;
        logic            w_ge;
        logic [FRIC_W:0] w_diff;
        assign w_trial = {r_st[k].rem, r_st[k].num[NUM_W-1]};
        assign w_ge    = w_trial >= {1'b0, r_st[k].d};
        assign w_diff  = w_trial - {1'b0, r_st[k].d};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k+1].rem_hi <= r_st[k].rem_hi;
                r_st[k+1].rem    <= w_ge ? w_diff[FRIC_W-1:0] : w_trial[FRIC_W-1:0];
                r_st[k+1].num    <= {r_st[k].num[NUM_W-2:0], 1'b0};
                r_st[k+1].quo    <= {r_st[k].quo[NUM_W-2:0], w_ge};
                r_st[k+1].d      <= r_st[k].d;
                r_st[k+1].neg    <= r_st[k].neg;
                r_st[k+1].byp    <= r_st[k].byp;
                r_st[k+1].vx     <= r_st[k].vx;
            end
        end
    end

    assign w_q = r_st[NUM_W].quo;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_st[NUM_W].byp) begin
                o_vx <= $signed(r_st[NUM_W].vx);
            end else if (r_st[NUM_W].neg) begin
                o_vx <= (w_q > MAX_NEG) ? $signed(MAX_NEG[DATA_W-1:0])
                                        : $signed(DATA_W'(-w_q));
            end else begin
                o_vx <= (w_q > MAX_POS) ? $signed(MAX_POS[DATA_W-1:0])
                                        : $signed(w_q[DATA_W-1:0]);
            end
        end
    end

    logic unused_r;
    assign unused_r = ^r_st[NUM_W].rem_hi ^ ^r_st[NUM_W].rem ^ ^r_st[NUM_W].num
                    ^ ^r_st[NUM_W].d;

endmodule
`default_nettype wire

@@ sv/body_motion_integrator_2d.sv @@
// top level of the two-axis body motion integrator
// one body word in, one updated body word out, in order
// input channel: i_valid with o_stall; a word is taken when i_valid is high and
//   o_stall is low
// output channel: o_valid with i_stall; a result is taken when o_valid is high
//   and i_stall is low
// throughput: one body per unstalled cycle, fully pipelined, words independent
// pipeline: the two dt scaling units (multiply, reciprocal multiply by 1/1000,
//   correction), the friction divider (39 one-bit-per-stage steps plus its
//   input and output registers), and the velocity clamp and box clamp stages
// config: i_cfg_we writes register i_cfg_idx with i_cfg_data;
//   write only while no body is in flight
// reset: clears the valid chain and loads the default config (no gravity, box
//   from 0 to max positive, rest threshold one lsb)
// stall: while the output holds a result and i_stall is high the whole pipeline
//   freezes and o_stall is raised; nothing is dropped or repeated
`default_nettype none
module body_motion_integrator_2d
    import bmi_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic signed [DATA_W-1:0] i_pos_x,
    input  wire logic signed [DATA_W-1:0] i_pos_y,
    input  wire logic signed [DATA_W-1:0] i_vel_x,
    input  wire logic signed [DATA_W-1:0] i_vel_y,
    input  wire logic signed [DATA_W-1:0] i_acc_x,
    input  wire logic signed [DATA_W-1:0] i_acc_y,
    input  wire logic [LIM_W-1:0]         i_speed_limit_x,
    input  wire logic [LIM_W-1:0]         i_speed_limit_y,
    input  wire logic [FRIC_W-1:0]        i_friction_div,
    input  wire logic                     i_gravity_on,
    input  wire logic [MS_W-1:0]          i_step_ms,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic signed [DATA_W-1:0]      o_new_pos_x,
    output logic signed [DATA_W-1:0]      o_new_pos_y,
    output logic signed [DATA_W-1:0]      o_new_vel_x,
    output logic signed [DATA_W-1:0]      o_new_vel_y,
    output logic                          o_side_hit,
    output logic                          o_on_floor,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [DATA_W-1:0]        i_cfg_data
);

    logic signed [DATA_W-1:0] r_gravity, r_xmin, r_xmax, r_ymin, r_ymax;
    logic [REST_W-1:0]        r_rest;
    logic [TOT_LAT-1:0]       r_vld;
    logic                     w_en;

    assign w_en    = !(r_vld[TOT_LAT-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[TOT_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= RST_GRAVITY;
            r_xmin    <= RST_XMIN;
            r_xmax    <= RST_XMAX;
            r_ymin    <= RST_YMIN;
            r_ymax    <= RST_YMAX;
            r_rest    <= RST_REST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GRAVITY: r_gravity <= $signed(i_cfg_data);
                CFG_XMIN:    r_xmin    <= $signed(i_cfg_data);
                CFG_XMAX:    r_xmax    <= $signed(i_cfg_data);
                CFG_YMIN:    r_ymin    <= $signed(i_cfg_data);
                CFG_YMAX:    r_ymax    <= $signed(i_cfg_data);
                CFG_REST:    r_rest    <= i_cfg_data[REST_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[TOT_LAT-2:0], i_valid};
        end
    end

    // phase a: acceleration and gravity times dt
    logic signed [SCL_W-1:0]  w_sx, w_sy, w_sg;
    logic signed [DATA_W-1:0] w_g;
    t_side_a                  r_sa [SC_LAT];

    assign w_g = i_gravity_on ? r_gravity : '0;

    bmi_div1k u_sc_ax (.i_clk(i_clk), .i_en(w_en), .i_v(i_acc_x), .i_ms(i_step_ms),
                       .o_q(w_sx));
    bmi_div1k u_sc_ay (.i_clk(i_clk), .i_en(w_en), .i_v(i_acc_y), .i_ms(i_step_ms),
                       .o_q(w_sy));
    bmi_div1k u_sc_g  (.i_clk(i_clk), .i_en(w_en), .i_v(w_g), .i_ms(i_step_ms),
                       .o_q(w_sg));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sa[0] <= '{px: i_pos_x, py: i_pos_y, vx: i_vel_x, vy: i_vel_y,
                         limx: i_speed_limit_x, limy: i_speed_limit_y,
                         fdiv: i_friction_div, ms: i_step_ms};
            for (int k = 1; k < SC_LAT; k++) begin
                r_sa[k] <= r_sa[k-1];
            end
        end
    end

    // phase b: velocity update, clamp and rest snap
    function automatic logic signed [DATA_W-1:0] clamp_snap(
        input logic signed [DATA_W+2:0] v,
        input logic [LIM_W-1:0]         lim,
        input logic [REST_W-1:0]        rest
    );
        logic signed [DATA_W+2:0] l;
        logic signed [DATA_W+2:0] c;
        logic [DATA_W+2:0]        a;
        l = $signed({4'b0, lim});
        if (v < -l) begin
            c = -l;
        end else if (v > l) begin
            c = l;
        end else begin
            c = v;
        end
        a = c[DATA_W+2] ? (DATA_W+3)'(-c) : (DATA_W+3)'(c);
        if (a < (DATA_W+3)'(rest)) begin
            return '0;
        end
        return $signed(c[DATA_W-1:0]);
    endfunction

    logic signed [DATA_W+2:0] w_vx_sum, w_vy_sum;
    logic signed [DATA_W-1:0] r_b_vx, r_b_vy, r_b_px, r_b_py;
    logic [FRIC_W-1:0]        r_b_fdiv;
    logic [MS_W-1:0]          r_b_ms;

    assign w_vx_sum = (DATA_W+3)'(r_sa[SC_LAT-1].vx) + (DATA_W+3)'(w_sx);
    assign w_vy_sum = (DATA_W+3)'(r_sa[SC_LAT-1].vy) + (DATA_W+3)'(w_sy)
                    + (DATA_W+3)'(w_sg);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_vx   <= clamp_snap(w_vx_sum, r_sa[SC_LAT-1].limx, r_rest);
            r_b_vy   <= clamp_snap(w_vy_sum, r_sa[SC_LAT-1].limy, r_rest);
            r_b_px   <= r_sa[SC_LAT-1].px;
            r_b_py   <= r_sa[SC_LAT-1].py;
            r_b_fdiv <= r_sa[SC_LAT-1].fdiv;
            r_b_ms   <= r_sa[SC_LAT-1].ms;
        end
    end

    // phase c: friction divide on x velocity
    logic signed [DATA_W-1:0] w_vx_f;
    t_side_c                  r_sc [DIV_LAT];

    bmi_fric_div u_fric (.i_clk(i_clk), .i_en(w_en), .i_vx(r_b_vx), .i_div(r_b_fdiv),
                         .o_vx(w_vx_f));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sc[0] <= '{px: r_b_px, py: r_b_py, vy: r_b_vy, ms: r_b_ms};
            for (int k = 1; k < DIV_LAT; k++) begin
                r_sc[k] <= r_sc[k-1];
            end
        end
    end

    // phase d: velocity times dt
    logic signed [SCL_W-1:0] w_dx, w_dy;
    t_side_d                 r_sd [SC_LAT];

    bmi_div1k u_sc_vx (.i_clk(i_clk), .i_en(w_en), .i_v(w_vx_f),
                       .i_ms(r_sc[DIV_LAT-1].ms), .o_q(w_dx));
    bmi_div1k u_sc_vy (.i_clk(i_clk), .i_en(w_en), .i_v(r_sc[DIV_LAT-1].vy),
                       .i_ms(r_sc[DIV_LAT-1].ms), .o_q(w_dy));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd[0] <= '{px: r_sc[DIV_LAT-1].px, py: r_sc[DIV_LAT-1].py,
                         vx: w_vx_f, vy: r_sc[DIV_LAT-1].vy};
            for (int k = 1; k < SC_LAT; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // phase e: position update and world box clamp
    logic signed [DATA_W+1:0] w_px, w_py;
    logic signed [DATA_W-1:0] w_px_c, w_py_c;
    logic                     w_hit, w_floor;

    assign w_px = (DATA_W+2)'(r_sd[SC_LAT-1].px) + (DATA_W+2)'(w_dx);
    assign w_py = (DATA_W+2)'(r_sd[SC_LAT-1].py) + (DATA_W+2)'(w_dy);

    always_comb begin
        w_hit  = 1'b1;
        w_px_c = $signed(w_px[DATA_W-1:0]);
        if (w_px < (DATA_W+2)'(r_xmin)) begin
            w_px_c = r_xmin;
        end else if (w_px > (DATA_W+2)'(r_xmax)) begin
            w_px_c = r_xmax;
        end else begin
            w_hit = 1'b0;
        end
        w_py_c = $signed(w_py[DATA_W-1:0]);
        if (w_py < (DATA_W+2)'(r_ymin)) begin
            w_py_c = r_ymin;
        end else if (w_py > (DATA_W+2)'(r_ymax)) begin
            w_py_c = r_ymax;
        end
        w_floor = (w_py_c == r_ymin);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_new_pos_x <= w_px_c;
            o_new_pos_y <= w_py_c;
            o_new_vel_x <= w_hit ? '0 : r_sd[SC_LAT-1].vx;
            o_new_vel_y <= w_floor ? '0 : r_sd[SC_LAT-1].vy;
            o_side_hit  <= w_hit;
            o_on_floor  <= w_floor;
        end
    end

endmodule
`default_nettype wire

@@ sv/bmi_checker.sv @@
// port-level checks of the body motion integrator and their bind
`default_nettype none
`include "body_motion_integrator_2d_macros.svh"
module bmi_checker
    import bmi_pkg::*;
(
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     o_valid,
    input wire logic                     i_stall,
    input wire logic                     o_stall,
    input wire logic signed [DATA_W-1:0] o_new_vel_x,
    input wire logic signed [DATA_W-1:0] o_new_vel_y,
    input wire logic                     o_side_hit,
    input wire logic                     o_on_floor
);

    `BMI_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `BMI_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    `BMI_ASSERT_NOW(a_floor_vy, i_clk, i_rst_n, o_valid && o_on_floor, o_new_vel_y == '0)
    `BMI_ASSERT_NOW(a_wall_vx, i_clk, i_rst_n, o_valid && o_side_hit, o_new_vel_x == '0)

endmodule

bind body_motion_integrator_2d bmi_checker u_bmi_checker (.*);
`default_nettype wire

@@ tb/tb_body_motion_integrator_2d.sv @@
// self-checking testbench for the body motion integrator: directed table then random bodies
`default_nettype none
module tb_body_motion_integrator_2d;
    import bmi_pkg::*;

    typedef struct {
        logic signed [DATA_W-1:0] px, py, vx, vy, ax, ay;
        logic [LIM_W-1:0]         limx, limy;
        logic [FRIC_W-1:0]        fdiv;
        logic                     grav;
        logic [MS_W-1:0]          ms;
    } t_body;

    typedef struct {
        logic signed [DATA_W-1:0] px, py, vx, vy;
        logic                     hit, flr;
    } t_motion;

    localparam int N_DIR = 12;

    logic i_clk, i_rst_n, i_valid, o_stall, o_valid, i_stall;
    logic signed [DATA_W-1:0] i_pos_x, i_pos_y, i_vel_x, i_vel_y, i_acc_x, i_acc_y;
    logic [LIM_W-1:0] i_speed_limit_x, i_speed_limit_y;
    logic [FRIC_W-1:0] i_friction_div;
    logic i_gravity_on;
    logic [MS_W-1:0] i_step_ms;
    logic signed [DATA_W-1:0] o_new_pos_x, o_new_pos_y, o_new_vel_x, o_new_vel_y;
    logic o_side_hit, o_on_floor;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DATA_W-1:0] i_cfg_data;

    body_motion_integrator_2d u_dut (.*);

    // world settings as the predictor sees them
    longint grav_acc, x_lo, x_hi, y_lo, y_hi, rest_min;

    t_motion motion_q[$];
    int      n_err, n_checked, n_hits, n_floor, n_bodies, n_cfg;
    bit      idle_on, hold_req;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(20 * 2000000);
        $display("TB_ERROR");
        $finish;
    end

    function automatic longint clamp_sym(longint v, longint lim);
        if (v < -lim) return -lim;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic longint snap_slow(longint v);
        longint m;
        m = (v < 0) ? -v : v;
        return (m < rest_min) ? 0 : v;
    endfunction

    function automatic t_motion advance_body(t_body b);
        longint ms, vx, vy, px, py, fd;
        t_motion r;
        ms = b.ms;
        fd = b.fdiv;
        vx = longint'(b.vx) + (longint'(b.ax) * ms) / 1000;
        vy = longint'(b.vy) + (longint'(b.ay) * ms) / 1000;
        if (b.grav) vy += (grav_acc * ms) / 1000;
        vx = snap_slow(clamp_sym(vx, longint'(b.limx)));
        vy = snap_slow(clamp_sym(vy, longint'(b.limy)));
        if (vx != 0 && fd != 0) begin
            vx = (vx * 256) / fd;
            if (vx > 64'sd2147483647) vx = 64'sd2147483647;
            if (vx < -64'sd2147483648) vx = -64'sd2147483648;
        end
        px = longint'(b.px) + (vx * ms) / 1000;
        py = longint'(b.py) + (vy * ms) / 1000;
        r.hit = 1'b0;
        if (px < x_lo) begin
            px = x_lo;
            r.hit = 1'b1;
        end else if (px > x_hi) begin
            px = x_hi;
            r.hit = 1'b1;
        end
        if (py < y_lo) py = y_lo;
        else if (py > y_hi) py = y_hi;
        if (r.hit) vx = 0;
        r.flr = (py == y_lo);
        if (r.flr) vy = 0;
        r.px = px[31:0];
        r.py = py[31:0];
        r.vx = vx[31:0];
        r.vy = vy[31:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        n_err++;
        $display("mismatch on result %0d: %s got %0h want %0h", n_checked, field, got, want);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_motion e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (motion_q.size() == 0) begin
                n_err++;
                $display("unexpected result word");
            end else begin
                e = motion_q.pop_front();
                if (o_new_pos_x !== e.px) report_mismatch("new_pos_x", o_new_pos_x, e.px);
                if (o_new_pos_y !== e.py) report_mismatch("new_pos_y", o_new_pos_y, e.py);
                if (o_new_vel_x !== e.vx) report_mismatch("new_vel_x", o_new_vel_x, e.vx);
                if (o_new_vel_y !== e.vy) report_mismatch("new_vel_y", o_new_vel_y, e.vy);
                if (o_side_hit !== e.hit) report_mismatch("side_hit", o_side_hit, e.hit);
                if (o_on_floor !== e.flr) report_mismatch("on_floor", o_on_floor, e.flr);
                n_hits += e.hit;
                n_floor += e.flr;
            end
            n_checked++;
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        bit s;
        int n;
        i_stall <= 1'b0;
        forever begin
            if (hold_req) begin
                s = 1'b1;
                n = 300;
            end else begin
                s = idle_on && ($urandom_range(0, 3) == 0);
                n = s ? $urandom_range(1, 13) : 1;
            end
            i_stall <= s;
            repeat (n) @(posedge i_clk);
            if (s && hold_req) hold_req = 1'b0;
        end
    end

    task automatic send_body(t_body b, t_motion e);
        i_pos_x <= b.px;
        i_pos_y <= b.py;
        i_vel_x <= b.vx;
        i_vel_y <= b.vy;
        i_acc_x <= b.ax;
        i_acc_y <= b.ay;
        i_speed_limit_x <= b.limx;
        i_speed_limit_y <= b.limy;
        i_friction_div <= b.fdiv;
        i_gravity_on <= b.grav;
        i_step_ms <= b.ms;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        motion_q.push_back(e);
        n_bodies++;
        if (idle_on && !hold_req && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    task automatic drain_pipe();
        i_valid <= 1'b0;
        while (motion_q.size() != 0) @(posedge i_clk);
        repeat (TOT_LAT + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_cfg++;
        case (idx)
            CFG_GRAVITY: grav_acc = longint'(signed'(val));
            CFG_XMIN:    x_lo = longint'(signed'(val));
            CFG_XMAX:    x_hi = longint'(signed'(val));
            CFG_YMIN:    y_lo = longint'(signed'(val));
            CFG_YMAX:    y_hi = longint'(signed'(val));
            CFG_REST:    rest_min = val[15:0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rnd_word();
        logic [31:0] w;
        case ($urandom_range(0, 6))
            0, 1: return $urandom;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'h0;
            default: begin
                w = $urandom_range(0, 1 << 22);
                return $urandom_range(0, 1) ? -w : w;
            end
        endcase
    endfunction

    function automatic logic [30:0] rnd_limit();
        case ($urandom_range(0, 4))
            0: return 31'h7FFF_FFFF;
            1: return 31'h0;
            2: return 31'($urandom);
            default: return 31'($urandom_range(0, 1 << 24));
        endcase
    endfunction

    function automatic t_body rnd_body();
        t_body b;
        b.px = rnd_word();
        b.py = rnd_word();
        b.vx = rnd_word();
        b.vy = rnd_word();
        b.ax = rnd_word();
        b.ay = rnd_word();
        b.limx = rnd_limit();
        b.limy = rnd_limit();
        case ($urandom_range(0, 4))
            0: b.fdiv = 16'd0;
            1: b.fdiv = 16'd256;
            2: b.fdiv = 16'($urandom_range(1, 512));
            default: b.fdiv = 16'($urandom);
        endcase
        b.grav = 1'($urandom_range(0, 1));
        b.ms = ($urandom_range(0, 15) == 0) ? 10'($urandom_range(1001, 1023))
                                             : 10'($urandom_range(0, 1000));
        return b;
    endfunction

    function automatic t_body mk_body(logic [31:0] px, py, vx, vy, ax, ay,
                                      logic [30:0] lx, ly, logic [15:0] fd,
                                      logic g, logic [9:0] ms);
        t_body b;
        b.px = px; b.py = py; b.vx = vx; b.vy = vy; b.ax = ax; b.ay = ay;
        b.limx = lx; b.limy = ly; b.fdiv = fd; b.grav = g; b.ms = ms;
        return b;
    endfunction

    initial begin
        t_body   dir_body[N_DIR];
        bit      dir_fixed[N_DIR];
        t_motion dir_exp[N_DIR];
        t_motion e;
        t_body   b;
        logic [31:0] lo, hi;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_GRAVITY;
        i_cfg_data <= '0;
        i_pos_x <= '0; i_pos_y <= '0; i_vel_x <= '0; i_vel_y <= '0;
        i_acc_x <= '0; i_acc_y <= '0; i_speed_limit_x <= '0; i_speed_limit_y <= '0;
        i_friction_div <= '0; i_gravity_on <= 1'b0; i_step_ms <= '0;
        idle_on = 1'b1;
        hold_req = 1'b0;
        grav_acc = 0; x_lo = 0; x_hi = 32'h7FFF_FFFF; y_lo = 0; y_hi = 32'h7FFF_FFFF;
        rest_min = 1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows under reset settings
        dir_fixed = '{default: 1'b0};
        dir_body[0] = mk_body(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        dir_fixed[0] = 1'b1;
        dir_exp[0] = '{px: 0, py: 0, vx: 0, vy: 0, hit: 1'b0, flr: 1'b1};
        // left of the wall with nothing moving
        dir_body[1] = mk_body(-5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        dir_fixed[1] = 1'b1;
        dir_exp[1] = '{px: 0, py: 0, vx: 0, vy: 0, hit: 1'b1, flr: 1'b1};
        dir_body[2] = mk_body(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                              16'hFFFF, 1, 1000);
        dir_body[3] = mk_body(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                              0, 1, 1023);
        dir_body[4] = mk_body(1000, 1000, 32'h0001_0000, 0, 0, 0, 31'h7FFF_FFFF, 0, 0, 0, 500);
        dir_body[5] = mk_body(32'h4000_0000, 10, 32'h7000_0000, 5, 0, 0, 31'h7FFF_FFFF,
                              31'h7FFF_FFFF, 1, 0, 1);
        dir_body[6] = mk_body(32'h100_0000, 50, -32'h10000, 0, 0, 0, 31'h7FFF_FFFF, 10,
                              256, 0, 1000);
        dir_body[7] = mk_body(32'h100_0000, 50, 32'h10000, 3, -32'h2_0000, 0, 31'h7FFF_FFFF,
                              10, 16'hFFFF, 0, 300);
        dir_body[8] = mk_body(777, 32'h7FFF_0000, 12345, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF,
                              100, 31'h7FFF_FFFF, 128, 1, 1000);
        dir_body[9] = mk_body(32'h7FFF_FFF0, 123, 32'h7FFF_FFFF, -1, 32'h7FFF_FFFF, -1,
                              31'h7FFF_FFFF, 5, 2, 0, 999);
        dir_body[10] = mk_body(0, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 1, 1000);
        dir_body[11] = mk_body(5, 32'h10_0000, 1, -1, 1, 1, 3, 3, 256, 0, 1001);
        for (int i = 0; i < N_DIR; i++) begin
            e = dir_fixed[i] ? dir_exp[i] : advance_body(dir_body[i]);
            send_body(dir_body[i], e);
        end

        for (int ph = 0; ph < 9; ph++) begin
            drain_pipe();
            case (ph)
                0: ;
                1: begin
                    write_reg(CFG_GRAVITY, 32'h7FFF_FFFF);
                    write_reg(CFG_XMIN, 32'h8000_0000);
                    write_reg(CFG_XMAX, 32'h7FFF_FFFF);
                    write_reg(CFG_YMIN, 32'h8000_0000);
                    write_reg(CFG_YMAX, 32'h7FFF_FFFF);
                    write_reg(CFG_REST, 32'h0);
                end
                2: begin
                    // inverted box, min above max
                    write_reg(CFG_GRAVITY, 32'h8000_0000);
                    write_reg(CFG_XMIN, 32'h7FFF_FFFF);
                    write_reg(CFG_XMAX, 32'h8000_0000);
                    write_reg(CFG_YMIN, 32'h1000);
                    write_reg(CFG_YMAX, -32'h1000);
                    write_reg(CFG_REST, 32'hFFFF);
                end
                default: begin
                    lo = -$urandom_range(0, 1 << 23);
                    hi = $urandom_range(0, 1 << 23);
                    write_reg(CFG_GRAVITY, ($urandom_range(0, 2) == 0) ? $urandom
                                           : -$urandom_range(0, 1 << 20));
                    write_reg(CFG_XMIN, lo);
                    write_reg(CFG_XMAX, hi);
                    write_reg(CFG_YMIN, -$urandom_range(0, 1 << 23));
                    write_reg(CFG_YMAX, $urandom_range(0, 1 << 23));
                    write_reg(CFG_REST, $urandom_range(0, 1) ? $urandom_range(0, 65535)
                                        : $urandom_range(0, 64));
                end
            endcase
            idle_on = (ph != 4) && (ph != 8);
            if (ph == 5) hold_req = 1'b1;
            for (int k = 0; k < 200; k++) begin
                b = rnd_body();
                send_body(b, advance_body(b));
            end
        end

        drain_pipe();
        repeat (TOT_LAT + 10) @(posedge i_clk);
        $display("covered %0d bodies, %0d results checked over %0d register writes",
                 n_bodies, n_checked, n_cfg);
        $display("wall hits seen %0d, floor contacts seen %0d", n_hits, n_floor);
        if (n_err == 0 && motion_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
